// ===== src/assert_macros.svh =====
// Assertion macros shared by the circle collision resolve RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

// ===== src/ccr_pkg.sv =====
// Widths, sideband structs and saturation helper for the circle collision resolver.
// Depends on nothing; imported by the top level and the testbench.
package ccr_pkg;

	localparam int POS_W   = 32;
	localparam int RAD_W   = 31;
	localparam int MASS_W  = 24;
	localparam int DIFF_W  = 33;
	localparam int AXIS_W  = 32;
	localparam int SUM_W   = 32;
	localparam int TOT_W   = 25;
	localparam int SQX_W   = 65;
	localparam int SQ_W    = 66;
	localparam int RS2_W   = 64;
	localparam int DIST_W  = 33;
	localparam int GAP_W   = 34;
	localparam int AG_W    = 33;
	localparam int PROD_W  = AG_W + MASS_W;
	localparam int T_W     = 33;
	localparam int MNUM_W  = AXIS_W + T_W;
	localparam int MOVE_W  = 33;
	localparam int NEWP_W  = 35;

	localparam int SQRT_STEPS_DEF = 3;
	localparam int DIV_STEPS_DEF  = 3;

	typedef logic signed [POS_W-1:0] pos_t;

	typedef struct packed {
		pos_t               x1;
		pos_t               y1;
		pos_t               x2;
		pos_t               y2;
		logic [SUM_W-1:0]   rs;
		logic [AXIS_W-1:0]  ax;
		logic [AXIS_W-1:0]  ay;
		logic               dxn;
		logic               dyn;
		logic [MASS_W-1:0]  m1;
		logic [MASS_W-1:0]  m2;
		logic [TOT_W-1:0]   tot;
		logic               ovl;
	} geo_t;

	typedef struct packed {
		pos_t               x1;
		pos_t               y1;
		pos_t               x2;
		pos_t               y2;
		logic [AXIS_W-1:0]  ax;
		logic [AXIS_W-1:0]  ay;
		logic               dxn;
		logic               dyn;
		logic               gneg;
		logic [DIST_W-1:0]  span;
		logic               ovl;
		logic               degen;
	} tside_t;

	typedef struct packed {
		pos_t               x1;
		pos_t               y1;
		pos_t               x2;
		pos_t               y2;
		logic               dxn;
		logic               dyn;
		logic               gneg;
		logic               ovl;
		logic               degen;
	} mside_t;

	// Clamp a widened position back to the signed 32-bit range.
	function automatic pos_t sat_pos(input logic signed [NEWP_W-1:0] v);
		logic [NEWP_W-POS_W:0] hi;
		hi = v[NEWP_W-1:POS_W-1];
		if (hi == '0 || hi == '1)
			return v[POS_W-1:0];
		else if (v[NEWP_W-1])
			return {1'b1, {(POS_W-1){1'b0}}};
		else
			return {1'b0, {(POS_W-1){1'b1}}};
	endfunction

endpackage

// ===== src/ccr_sqrt_pipe.sv =====
// Pipelined restoring integer square root, STEPS result bits per stage.
// Depends on nothing; carries a sideband vector alongside each request.
module ccr_sqrt_pipe #(
	parameter int IN_W   = 66,
	parameter int STEPS  = 3,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [IN_W-1:0]   in_rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [IN_W/2-1:0] out_root,
	output logic [SIDE_W-1:0] out_side
);

	localparam int ROOT_W = IN_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int NSTG   = (ROOT_W + STEPS - 1) / STEPS;

	logic              vld_s  [1:NSTG];
	logic [IN_W-1:0]   rad_s  [1:NSTG];
	logic [ROOT_W-1:0] root_s [1:NSTG];
	logic [REM_W-1:0]  rem_s  [1:NSTG];
	logic [SIDE_W-1:0] side_s [1:NSTG];

	for (genvar g = 0; g < NSTG; g++) begin : g_stage
		logic              c_vld;
		logic [IN_W-1:0]   c_rad, n_rad;
		logic [ROOT_W-1:0] c_root, n_root;
		logic [REM_W-1:0]  c_rem, n_rem;
		logic [SIDE_W-1:0] c_side;

		if (g == 0) begin : g_src
			assign c_vld  = in_valid;
			assign c_rad  = in_rad;
			assign c_root = '0;
			assign c_rem  = '0;
			assign c_side = in_side;
		end else begin : g_src
			assign c_vld  = vld_s[g];
			assign c_rad  = rad_s[g];
			assign c_root = root_s[g];
			assign c_rem  = rem_s[g];
			assign c_side = side_s[g];
		end

		always_comb begin
			logic [REM_W+1:0] r2;
			logic [REM_W+1:0] trial;
			n_rad  = c_rad;
			n_root = c_root;
			n_rem  = c_rem;
			for (int j = 0; j < STEPS; j++) begin
				if (g * STEPS + j < ROOT_W) begin
					r2    = {n_rem, n_rad[IN_W-1 -: 2]};
					trial = {2'b00, n_root, 2'b01};
					n_rad = n_rad << 2;
					if (r2 >= trial) begin
						n_rem  = REM_W'(r2 - trial);
						n_root = {n_root[ROOT_W-2:0], 1'b1};
					end else begin
						n_rem  = REM_W'(r2);
						n_root = {n_root[ROOT_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[g+1] <= 1'b0;
			else
				vld_s[g+1] <= c_vld;
		end

		always_ff @(posedge clk) begin
			rad_s[g+1]  <= n_rad;
			root_s[g+1] <= n_root;
			rem_s[g+1]  <= n_rem;
			side_s[g+1] <= c_side;
		end
	end

	assign out_valid = vld_s[NSTG];
	assign out_root  = root_s[NSTG];
	assign out_side  = side_s[NSTG];

endmodule

// ===== src/ccr_div_pipe.sv =====
// Pipelined restoring divider: LANES numerators over one shared divisor,
// STEPS quotient bits per stage. Depends on nothing; carries a sideband vector.
module ccr_div_pipe #(
	parameter int LANES  = 2,
	parameter int NUM_W  = 57,
	parameter int DEN_W  = 25,
	parameter int QUO_W  = 33,
	parameter int STEPS  = 3,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num [LANES],
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [QUO_W-1:0]  out_quo [LANES],
	output logic [SIDE_W-1:0] out_side
);

	localparam int NSTG = (QUO_W + STEPS - 1) / STEPS;

	// The quotient is known to fit QUO_W bits, so the upper numerator bits
	// already stand below the divisor and seed the partial remainder.
	logic              vld_s  [1:NSTG];
	logic [DEN_W-1:0]  rem_s  [1:NSTG][LANES];
	logic [QUO_W-1:0]  quo_s  [1:NSTG][LANES];
	logic [DEN_W-1:0]  den_s  [1:NSTG];
	logic [SIDE_W-1:0] side_s [1:NSTG];

	for (genvar g = 0; g < NSTG; g++) begin : g_stage
		logic              c_vld;
		logic [DEN_W-1:0]  c_rem [LANES];
		logic [QUO_W-1:0]  c_quo [LANES];
		logic [DEN_W-1:0]  n_rem [LANES];
		logic [QUO_W-1:0]  n_quo [LANES];
		logic [DEN_W-1:0]  c_den;
		logic [SIDE_W-1:0] c_side;

		if (g == 0) begin : g_src
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					c_rem[l] = DEN_W'(in_num[l][NUM_W-1:QUO_W]);
					c_quo[l] = in_num[l][QUO_W-1:0];
				end
			end
			assign c_vld  = in_valid;
			assign c_den  = in_den;
			assign c_side = in_side;
		end else begin : g_src
			always_comb begin
				for (int l = 0; l < LANES; l++) begin
					c_rem[l] = rem_s[g][l];
					c_quo[l] = quo_s[g][l];
				end
			end
			assign c_vld  = vld_s[g];
			assign c_den  = den_s[g];
			assign c_side = side_s[g];
		end

		always_comb begin
			logic [DEN_W:0] t;
			for (int l = 0; l < LANES; l++) begin
				n_rem[l] = c_rem[l];
				n_quo[l] = c_quo[l];
				for (int j = 0; j < STEPS; j++) begin
					if (g * STEPS + j < QUO_W) begin
						t = {n_rem[l], n_quo[l][QUO_W-1]};
						if (t >= {1'b0, c_den}) begin
							n_rem[l] = DEN_W'(t - {1'b0, c_den});
							n_quo[l] = {n_quo[l][QUO_W-2:0], 1'b1};
						end else begin
							n_rem[l] = DEN_W'(t);
							n_quo[l] = {n_quo[l][QUO_W-2:0], 1'b0};
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[g+1] <= 1'b0;
			else
				vld_s[g+1] <= c_vld;
		end

		always_ff @(posedge clk) begin
			for (int l = 0; l < LANES; l++) begin
				rem_s[g+1][l] <= n_rem[l];
				quo_s[g+1][l] <= n_quo[l];
			end
			den_s[g+1]  <= c_den;
			side_s[g+1] <= c_side;
		end
	end

	assign out_valid = vld_s[NSTG];
	assign out_quo   = quo_s[NSTG];
	assign out_side  = side_s[NSTG];

endmodule

// ===== src/circle_collision_resolve_unit.sv =====
// Top level of the circle pair collision resolver: overlap test, distance,
// mass split and position solve. Depends on ccr_pkg, ccr_sqrt_pipe, ccr_div_pipe, assert_macros.svh.
//
//  channel   handshake         payload
//  request   start / busy      first_x .. second_inv_mass
//  result    done (strobe)     overlap, degenerate, new_first_x .. new_second_y
//
// A request is taken in every cycle; busy is always low.
// Each result passes through the square root stages and the two divider chains.
// Each result shows for one cycle on done. No state survives an item; reset
// only clears the valid bits that travel down the pipeline.
`include "assert_macros.svh"

module circle_collision_resolve_unit
	import ccr_pkg::*;
#(
	parameter int SQRT_STEPS = SQRT_STEPS_DEF,
	parameter int DIV_STEPS  = DIV_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [POS_W-1:0]  first_x,
	input  logic [POS_W-1:0]  first_y,
	input  logic [POS_W-1:0]  second_x,
	input  logic [POS_W-1:0]  second_y,
	input  logic [RAD_W-1:0]  first_radius,
	input  logic [RAD_W-1:0]  second_radius,
	input  logic [MASS_W-1:0] first_inv_mass,
	input  logic [MASS_W-1:0] second_inv_mass,
	output logic              done,
	output logic              overlap,
	output logic              degenerate,
	output logic [POS_W-1:0]  new_first_x,
	output logic [POS_W-1:0]  new_first_y,
	output logic [POS_W-1:0]  new_second_x,
	output logic [POS_W-1:0]  new_second_y
);

	localparam int SQ_STG = (DIST_W + SQRT_STEPS - 1) / SQRT_STEPS;
	localparam int T_STG  = (T_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int M_STG  = (MOVE_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int LAT    = SQ_STG + T_STG + M_STG + 7;

	logic req_acc;
	assign busy    = 1'b0;
	assign req_acc = start && !busy;

	// Stage 1: differences and sums.
	logic                      vld_s1;
	pos_t                      x1_s1, y1_s1, x2_s1, y2_s1;
	logic signed [DIFF_W-1:0]  dx_s1, dy_s1;
	logic [SUM_W-1:0]          rs_s1;
	logic [MASS_W-1:0]         m1_s1, m2_s1;
	logic [TOT_W-1:0]          tot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= req_acc;
	end

	always_ff @(posedge clk) begin
		x1_s1  <= first_x;
		y1_s1  <= first_y;
		x2_s1  <= second_x;
		y2_s1  <= second_y;
		dx_s1  <= $signed({second_x[POS_W-1], second_x}) - $signed({first_x[POS_W-1], first_x});
		dy_s1  <= $signed({second_y[POS_W-1], second_y}) - $signed({first_y[POS_W-1], first_y});
		rs_s1  <= {1'b0, first_radius} + {1'b0, second_radius};
		m1_s1  <= first_inv_mass;
		m2_s1  <= second_inv_mass;
		tot_s1 <= {1'b0, first_inv_mass} + {1'b0, second_inv_mass};
	end

	// Stage 2: squares and axis magnitudes.
	logic                       vld_s2;
	pos_t                       x1_s2, y1_s2, x2_s2, y2_s2;
	logic [SQX_W-1:0]           sqx_s2, sqy_s2;
	logic [RS2_W-1:0]           rs2_s2;
	logic [SUM_W-1:0]           rs_s2;
	logic [AXIS_W-1:0]          ax_s2, ay_s2;
	logic                       dxn_s2, dyn_s2;
	logic [MASS_W-1:0]          m1_s2, m2_s2;
	logic [TOT_W-1:0]           tot_s2;
	logic signed [2*DIFF_W-1:0] sqx_c, sqy_c;
	logic signed [DIFF_W-1:0]   adx_c, ady_c;

	always_comb begin
		sqx_c = dx_s1 * dx_s1;
		sqy_c = dy_s1 * dy_s1;
		adx_c = dx_s1[DIFF_W-1] ? -dx_s1 : dx_s1;
		ady_c = dy_s1[DIFF_W-1] ? -dy_s1 : dy_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		x1_s2  <= x1_s1;
		y1_s2  <= y1_s1;
		x2_s2  <= x2_s1;
		y2_s2  <= y2_s1;
		sqx_s2 <= sqx_c[SQX_W-1:0];
		sqy_s2 <= sqy_c[SQX_W-1:0];
		rs2_s2 <= rs_s1 * rs_s1;
		rs_s2  <= rs_s1;
		ax_s2  <= adx_c[AXIS_W-1:0];
		ay_s2  <= ady_c[AXIS_W-1:0];
		dxn_s2 <= dx_s1[DIFF_W-1];
		dyn_s2 <= dy_s1[DIFF_W-1];
		m1_s2  <= m1_s1;
		m2_s2  <= m2_s1;
		tot_s2 <= tot_s1;
	end

	// Stage 3: squared distance and the overlap test.
	logic            vld_s3;
	logic [SQ_W-1:0] sq_s3;
	geo_t            geo_s3;
	logic [SQ_W-1:0] sq_c;

	assign sq_c = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		sq_s3      <= sq_c;
		geo_s3.x1  <= x1_s2;
		geo_s3.y1  <= y1_s2;
		geo_s3.x2  <= x2_s2;
		geo_s3.y2  <= y2_s2;
		geo_s3.rs  <= rs_s2;
		geo_s3.ax  <= ax_s2;
		geo_s3.ay  <= ay_s2;
		geo_s3.dxn <= dxn_s2;
		geo_s3.dyn <= dyn_s2;
		geo_s3.m1  <= m1_s2;
		geo_s3.m2  <= m2_s2;
		geo_s3.tot <= tot_s2;
		geo_s3.ovl <= sq_c <= {{(SQ_W-RS2_W){1'b0}}, rs2_s2};
	end

	logic              sq_vld;
	logic [DIST_W-1:0] dist_c;
	geo_t              geo_c;

	ccr_sqrt_pipe #(
		.IN_W   (SQ_W),
		.STEPS  (SQRT_STEPS),
		.SIDE_W ($bits(geo_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_rad    (sq_s3),
		.in_side   (geo_s3),
		.out_valid (sq_vld),
		.out_root  (dist_c),
		.out_side  (geo_c)
	);

	// Stage 4: gap and the degenerate test.
	logic                    vld_s4;
	tside_t                  ts_s4;
	logic [AG_W-1:0]         ag_s4;
	logic [MASS_W-1:0]       m1_s4, m2_s4;
	logic [TOT_W-1:0]        tot_s4;
	logic signed [GAP_W-1:0] gap_c;
	logic signed [GAP_W-1:0] agap_c;

	always_comb begin
		gap_c  = $signed({2'b00, geo_c.rs}) - $signed({1'b0, dist_c});
		agap_c = gap_c[GAP_W-1] ? -gap_c : gap_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= sq_vld;
	end

	always_ff @(posedge clk) begin
		ts_s4.x1    <= geo_c.x1;
		ts_s4.y1    <= geo_c.y1;
		ts_s4.x2    <= geo_c.x2;
		ts_s4.y2    <= geo_c.y2;
		ts_s4.ax    <= geo_c.ax;
		ts_s4.ay    <= geo_c.ay;
		ts_s4.dxn   <= geo_c.dxn;
		ts_s4.dyn   <= geo_c.dyn;
		ts_s4.gneg  <= gap_c[GAP_W-1];
		ts_s4.span  <= dist_c;
		ts_s4.ovl   <= geo_c.ovl;
		ts_s4.degen <= (dist_c == '0) || (geo_c.tot == '0);
		ag_s4       <= agap_c[AG_W-1:0];
		m1_s4       <= geo_c.m1;
		m2_s4       <= geo_c.m2;
		tot_s4      <= geo_c.tot;
	end

	// Stage 5: gap weighted by each inverse mass.
	logic              vld_s5;
	tside_t            ts_s5;
	logic [PROD_W-1:0] p_s5 [2];
	logic [TOT_W-1:0]  tot_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else
			vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		ts_s5   <= ts_s4;
		p_s5[0] <= ag_s4 * m1_s4;
		p_s5[1] <= ag_s4 * m2_s4;
		tot_s5  <= tot_s4;
	end

	logic           t_vld;
	logic [T_W-1:0] t_c [2];
	tside_t         ts_c;

	ccr_div_pipe #(
		.LANES  (2),
		.NUM_W  (PROD_W),
		.DEN_W  (TOT_W),
		.QUO_W  (T_W),
		.STEPS  (DIV_STEPS),
		.SIDE_W ($bits(tside_t))
	) u_share_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s5),
		.in_num    (p_s5),
		.in_den    (tot_s5),
		.in_side   (ts_s5),
		.out_valid (t_vld),
		.out_quo   (t_c),
		.out_side  (ts_c)
	);

	// Stage 6: shares projected on each axis, before dividing by the distance.
	// Lanes: first x, first y, second x, second y.
	logic              vld_s6;
	mside_t            ms_s6;
	logic [MNUM_W-1:0] a_s6 [4];
	logic [DIST_W-1:0] dist_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s6 <= 1'b0;
		else
			vld_s6 <= t_vld;
	end

	always_ff @(posedge clk) begin
		ms_s6.x1    <= ts_c.x1;
		ms_s6.y1    <= ts_c.y1;
		ms_s6.x2    <= ts_c.x2;
		ms_s6.y2    <= ts_c.y2;
		ms_s6.dxn   <= ts_c.dxn;
		ms_s6.dyn   <= ts_c.dyn;
		ms_s6.gneg  <= ts_c.gneg;
		ms_s6.ovl   <= ts_c.ovl;
		ms_s6.degen <= ts_c.degen;
		a_s6[0]     <= ts_c.ax * t_c[0];
		a_s6[1]     <= ts_c.ay * t_c[0];
		a_s6[2]     <= ts_c.ax * t_c[1];
		a_s6[3]     <= ts_c.ay * t_c[1];
		dist_s6     <= ts_c.span;
	end

	logic              m_vld;
	logic [MOVE_W-1:0] mv_c [4];
	mside_t            ms_c;

	ccr_div_pipe #(
		.LANES  (4),
		.NUM_W  (MNUM_W),
		.DEN_W  (DIST_W),
		.QUO_W  (MOVE_W),
		.STEPS  (DIV_STEPS),
		.SIDE_W ($bits(mside_t))
	) u_move_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s6),
		.in_num    (a_s6),
		.in_den    (dist_s6),
		.in_side   (ms_s6),
		.out_valid (m_vld),
		.out_quo   (mv_c),
		.out_side  (ms_c)
	);

	// Output stage: signed moves, saturating update, pass-through when degenerate.
	logic signed [NEWP_W-1:0] smv_c [4];
	logic signed [NEWP_W-1:0] n1x_c, n1y_c, n2x_c, n2y_c;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			// A move keeps its sign when the axis sign matches the gap sign and is negated otherwise.
			if (((l % 2 == 0) ? ms_c.dxn : ms_c.dyn) == ms_c.gneg)
				smv_c[l] = $signed({2'b00, mv_c[l]});
			else
				smv_c[l] = -$signed({2'b00, mv_c[l]});
		end
		n1x_c = $signed({{(NEWP_W-POS_W){ms_c.x1[POS_W-1]}}, ms_c.x1}) - smv_c[0];
		n1y_c = $signed({{(NEWP_W-POS_W){ms_c.y1[POS_W-1]}}, ms_c.y1}) - smv_c[1];
		n2x_c = $signed({{(NEWP_W-POS_W){ms_c.x2[POS_W-1]}}, ms_c.x2}) + smv_c[2];
		n2y_c = $signed({{(NEWP_W-POS_W){ms_c.y2[POS_W-1]}}, ms_c.y2}) + smv_c[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= m_vld;
	end

	always_ff @(posedge clk) begin
		overlap    <= ms_c.ovl;
		degenerate <= ms_c.degen;
		if (ms_c.degen) begin
			new_first_x  <= ms_c.x1;
			new_first_y  <= ms_c.y1;
			new_second_x <= ms_c.x2;
			new_second_y <= ms_c.y2;
		end else begin
			new_first_x  <= sat_pos(n1x_c);
			new_first_y  <= sat_pos(n1y_c);
			new_second_x <= sat_pos(n2x_c);
			new_second_y <= sat_pos(n2y_c);
		end
	end

	`ASSERT_ON(a_req_to_done, clk, arst_n, req_acc |-> ##LAT done, "request lost in pipeline")
	`ASSERT_NEVER(a_no_extra_done, clk, arst_n, done && !$past(req_acc, LAT), "result without request")
	`ASSERT_ON(a_degen_pass, clk, arst_n, done && degenerate |-> new_first_x == $past(first_x, LAT) && new_second_y == $past(second_y, LAT), "degenerate pair moved")

endmodule

// ===== sim/tb_circle_collision_resolve_unit.sv =====
// Self-checking testbench for circle_collision_resolve_unit: random and directed circle pairs.
// Depends on ccr_pkg and the resolver RTL; predicts every result with exact wide integers.
`timescale 1ns / 100ps

module tb_circle_collision_resolve_unit;
	import ccr_pkg::*;

	typedef struct packed {
		logic [31:0] x1, y1, x2, y2;
		logic [30:0] r1, r2;
		logic [23:0] m1, m2;
	} pair_t;

	typedef struct packed {
		logic        ovl, degen;
		logic [31:0] n1x, n1y, n2x, n2y;
	} solved_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, overlap, degenerate;
	logic [31:0] first_x = '0, first_y = '0, second_x = '0, second_y = '0;
	logic [30:0] first_radius = '0, second_radius = '0;
	logic [23:0] first_inv_mass = '0, second_inv_mass = '0;
	logic [31:0] new_first_x, new_first_y, new_second_x, new_second_y;

	pair_t   pending_pairs[$];
	solved_t expected_positions[$];
	int      mismatches = 0;
	int      results_seen = 0;
	int      overlaps_seen = 0;
	int      degens_seen = 0;
	int      cycle_count = 0;
	bit      stimulus_done = 1'b0;
	bit      idle_free = 1'b0;

	circle_collision_resolve_unit u_top (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [32:0] floor_sqrt(input logic [65:0] v);
		logic [32:0] root;
		logic [67:0] rem, trial;
		root = '0;
		rem = '0;
		for (int i = 32; i >= 0; i--) begin
			rem = (rem << 2) | v[2*i +: 2];
			trial = ({35'd0, root} << 2) | 68'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 33'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic logic signed [127:0] clamp_pos(input logic signed [127:0] v);
		if (v > 128'sd2147483647)
			return 128'sd2147483647;
		if (v < -128'sd2147483648)
			return -128'sd2147483648;
		return v;
	endfunction

	function automatic solved_t resolve_pair(input pair_t p);
		logic signed [127:0] x1, y1, x2, y2, dx, dy, gap, mvx1, mvy1, mvx2, mvy2;
		logic [127:0] ax, ay, sq, rs, span, total, ag, t1, t2;
		solved_t s;
		x1 = $signed(p.x1);
		y1 = $signed(p.y1);
		x2 = $signed(p.x2);
		y2 = $signed(p.y2);
		dx = x2 - x1;
		dy = y2 - y1;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		sq = ax * ax + ay * ay;
		rs = p.r1 + p.r2;
		span = floor_sqrt(sq[65:0]);
		total = p.m1 + p.m2;
		s.ovl = sq <= rs * rs;
		s.degen = span == 0 || total == 0;
		s.n1x = p.x1;
		s.n1y = p.y1;
		s.n2x = p.x2;
		s.n2y = p.y2;
		if (!s.degen) begin
			gap = $signed(rs) - $signed(span);
			ag = gap < 0 ? -gap : gap;
			t1 = ag * p.m1 / total;
			t2 = ag * p.m2 / total;
			mvx1 = $signed(ax * t1 / span);
			mvy1 = $signed(ay * t1 / span);
			mvx2 = $signed(ax * t2 / span);
			mvy2 = $signed(ay * t2 / span);
			// Move direction follows the axis sign, flipped when the gap pulls inward.
			if ((dx < 0) != (gap < 0)) begin
				mvx1 = -mvx1;
				mvx2 = -mvx2;
			end
			if ((dy < 0) != (gap < 0)) begin
				mvy1 = -mvy1;
				mvy2 = -mvy2;
			end
			s.n1x = 32'(clamp_pos(x1 - mvx1));
			s.n1y = 32'(clamp_pos(y1 - mvy1));
			s.n2x = 32'(clamp_pos(x2 + mvx2));
			s.n2y = 32'(clamp_pos(y2 + mvy2));
		end
		return s;
	endfunction

	function automatic logic [31:0] rand_coord(input int spread);
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, spread)
				: 32'h80000000 + $urandom_range(0, spread);
			default: return $urandom_range(0, 2 * spread) - spread;
		endcase
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int spread;
		spread = $urandom_range(0, 1) ? 32'h0040_0000 : 32'h3fff_ffff;
		p.x1 = rand_coord(spread);
		p.y1 = rand_coord(spread);
		// Mostly place the second circle nearby so that real contacts occur.
		if ($urandom_range(0, 3) != 0) begin
			p.x2 = p.x1 + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
			p.y2 = p.y1 + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		end else begin
			p.x2 = rand_coord(spread);
			p.y2 = rand_coord(spread);
		end
		p.r1 = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0004_0000));
		p.r2 = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 32'h0004_0000));
		p.m1 = $urandom_range(0, 7) == 0 ? 24'd0 : 24'($urandom);
		p.m2 = $urandom_range(0, 7) == 0 ? 24'd0 : 24'($urandom);
		if ($urandom_range(0, 19) == 0) begin
			p.x2 = p.x1;
			p.y2 = p.y1;
		end
		return p;
	endfunction

	function automatic pair_t make_pair(input logic [31:0] x1, y1, x2, y2,
			input logic [30:0] r1, r2, input logic [23:0] m1, m2);
		pair_t p;
		p = '{x1, y1, x2, y2, r1, r2, m1, m2};
		return p;
	endfunction

	initial begin
		// Overlapping, separated, coincident, static and saturating pairs.
		pending_pairs.push_back(make_pair(0, 0, 32'h0001_0000, 0, 31'h0001_0000,
			31'h0001_0000, 24'h01_0000, 24'h01_0000));
		pending_pairs.push_back(make_pair(0, 0, 32'h0003_0000, 32'h0004_0000,
			31'h0001_0000, 31'h0001_0000, 24'h01_0000, 24'h02_0000));
		pending_pairs.push_back(make_pair(32'hfff0_0000, 32'h0010_0000, 32'h0010_0000,
			32'hfff0_0000, 31'h0001_0000, 31'h0002_0000, 24'h00_8000, 24'h00_0000));
		pending_pairs.push_back(make_pair(32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
			32'h1234_5678, 31'h7fff_ffff, 31'h7fff_ffff, 24'hff_ffff, 24'hff_ffff));
		pending_pairs.push_back(make_pair(0, 0, 32'h0000_8000, 0, 31'h0001_0000, 0, 0, 0));
		pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 24'hff_ffff, 24'hff_ffff));
		pending_pairs.push_back(make_pair(32'h7fff_0000, 32'h8000_1000, 32'h7fff_1000,
			32'h8000_0000, 31'h7fff_ffff, 31'h7fff_ffff, 24'hff_ffff, 24'h00_0001));
		pending_pairs.push_back(make_pair(32'h8000_0000, 0, 32'h7fff_ffff, 0, 0, 0,
			24'h00_0001, 24'hff_ffff));
		pending_pairs.push_back(make_pair(32'hffff_ffff, 32'hffff_ffff, 0, 0,
			31'h5555_5555, 31'h2aaa_aaaa, 24'haa_aaaa, 24'h55_5555));
		pending_pairs.push_back(make_pair(0, 32'h7fff_ffff, 0, 32'h8000_0000, 0, 0,
			24'hff_ffff, 0));
		for (int i = 0; i < 500; i++)
			pending_pairs.push_back(random_pair());
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Request driver: one pair per accepted start, random gaps outside the no-gap window.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				void'(pending_pairs.pop_front());
			idle_free <= (cycle_count > 200 && cycle_count < 450);
			if (pending_pairs.size() > 0
					&& (idle_free || $urandom_range(0, 99) >= 22)) begin
				pair_t p;
				p = pending_pairs[0];
				start <= 1'b1;
				{first_x, first_y, second_x, second_y, first_radius, second_radius,
					first_inv_mass, second_inv_mass} <= p;
			end else begin
				start <= 1'b0;
				if (pending_pairs.size() == 0)
					stimulus_done <= 1'b1;
			end
		end
	end

	// Result monitor: predict on acceptance, compare each strobed result with the oldest.
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (start && !busy)
				expected_positions.push_back(resolve_pair({first_x, first_y, second_x,
					second_y, first_radius, second_radius, first_inv_mass, second_inv_mass}));
			if (done) begin
				solved_t got, exp_s;
				got = '{overlap, degenerate, new_first_x, new_first_y, new_second_x,
					new_second_y};
				results_seen <= results_seen + 1;
				overlaps_seen <= overlaps_seen + overlap;
				degens_seen <= degens_seen + degenerate;
				if (expected_positions.size() == 0) begin
					mismatches <= mismatches + 1;
					$display("%0t: unexpected result %h", $time, got);
				end else begin
					exp_s = expected_positions.pop_front();
					if (got !== exp_s) begin
						mismatches <= mismatches + 1;
						$display("%0t: mismatch expected ovl=%b dg=%b %h %h %h %h", $time,
							exp_s.ovl, exp_s.degen, exp_s.n1x, exp_s.n1y, exp_s.n2x, exp_s.n2y);
						$display("%0t:          actual   ovl=%b dg=%b %h %h %h %h", $time,
							got.ovl, got.degen, got.n1x, got.n1y, got.n2x, got.n2y);
					end
				end
			end
		end
	end

	initial begin
		int drain;
		drain = 0;
		while (!(stimulus_done && expected_positions.size() == 0) && cycle_count < 200000)
			@(posedge clk);
		while (drain < 80 && cycle_count < 200000) begin
			@(posedge clk);
			drain++;
		end
		$display("Resolved %0d circle pairs: %0d overlapping, %0d degenerate.",
			results_seen, overlaps_seen, degens_seen);
		if (cycle_count >= 200000) begin
			$display("Timed out with %0d requests still outstanding.",
				expected_positions.size());
			$display("end of test: mismatches");
		end else if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
